>>> src/bvve_pkg.sv
// Package for the barometric vertical velocity estimator.
// Holds the fixed field widths, the smoothing constants and the item payload type.
// Depends on nothing; every file in src but bvve_checker imports it.
package bvve_pkg;

	// Field widths fixed by the sample format.
	localparam int unsigned DATA_W = 32;
	localparam int unsigned DIFF_W = DATA_W + 1;

	// Gain of 40 on the altitude step, built as (d << 5) + (d << 3).
	localparam int unsigned GAIN_SH_HI = 5;
	localparam int unsigned GAIN_SH_LO = 3;
	localparam int unsigned GAIN_W = DIFF_W + 6;

	// Decay weight of 0.2 as 13107 / 65536, rounded towards minus infinity.
	localparam int unsigned DECAY_MUL_W = 15;
	localparam logic signed [DECAY_MUL_W-1:0] DECAY_MUL = 15'sd13107;
	localparam int unsigned DECAY_SHIFT = 16;
	localparam int unsigned PROD_W = DATA_W + DECAY_MUL_W;
	localparam int unsigned DECAY_W = PROD_W - DECAY_SHIFT;

	// Width of the unsaturated velocity sum and the saturation limits.
	localparam int unsigned VSUM_W = GAIN_W + 1;
	localparam logic signed [DATA_W-1:0] VEL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] VEL_MIN = 32'sh8000_0000;

	// Payload that travels with each sample down the pipeline.
	typedef struct packed {
		logic signed [DATA_W-1:0] alt;
		logic signed [DATA_W-1:0] vel;
	} item_t;

endpackage

>>> src/baro_vertical_velocity_estimator.sv
// Barometric vertical velocity estimator. One altitude sample (1/256 m, signed) enters per
// beat and one result beat leaves per sample, carrying the altitude, the smoothed velocity
// and the mean of the last WINDOW_LEN velocities. A new sample is taken in every cycle while
// the output keeps up. The path runs through three front stages, one stage for the running
// window sum, three for the average (magnitude, partial products of a reciprocal
// multiplication, then sum and shift) and the output register. When the output stalls, one
// further beat waits in a skid stage and the input closes until it has drained.
// The window is a shift line of WINDOW_LEN cells with a running sum.
// Depends on bvve_pkg, bvve_velocity, bvve_win_cell and bvve_div_cell.
module baro_vertical_velocity_estimator #(
	parameter int unsigned WINDOW_LEN = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // altitude [31:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata    // altitude_out [31:0], velocity [63:32], average_velocity [95:64]
);
	import bvve_pkg::*;

	localparam int unsigned SUM_W = DATA_W + $clog2(WINDOW_LEN);
	localparam int unsigned OUT_W = 3 * DATA_W;

	logic en;

	// Front end
	logic  v_valid;
	item_t v_item;

	// Window stage
	logic signed [DATA_W-1:0] win_q [WINDOW_LEN];
	logic signed [SUM_W-1:0]  sum_q;
	logic                     valid_s4;
	item_t                    item_s4;

	// Average
	logic              div_valid;
	item_t             div_item;
	logic [DATA_W-1:0] div_avg;

	// Output register and skid stage
	logic [OUT_W-1:0]  fin_data;
	logic              main_free;
	logic              main_valid_q, skid_valid_q;
	logic [OUT_W-1:0]  main_data_q, skid_data_q;

	// The pipeline moves whenever the skid stage is empty.
	assign en       = !skid_valid_q;
	assign s_tready = en;

	bvve_velocity u_velocity (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.altitude (s_tdata),
		.out_valid(v_valid),
		.out_item (v_item)
	);

	// Window shift line: the newest velocity enters at cell 0.
	for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_win
		if (i == 0) begin : g_head
			bvve_win_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (en && v_valid),
				.d     (v_item.vel),
				.q     (win_q[i])
			);
		end else begin : g_body
			bvve_win_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (en && v_valid),
				.d     (win_q[i-1]),
				.q     (win_q[i])
			);
		end
	end

	// Running sum: add the newest velocity, drop the one leaving the line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= v_valid;
			if (v_valid) begin
				sum_q <= sum_q + SUM_W'(v_item.vel) - SUM_W'(win_q[WINDOW_LEN-1]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s4 <= v_item;
		end
	end

	// Average of the window, truncated towards zero.
	bvve_div_cell #(
		.SUM_W  (SUM_W),
		.DIVISOR(WINDOW_LEN)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s4),
		.in_item  (item_s4),
		.in_sum   (sum_q),
		.out_valid(div_valid),
		.out_item (div_item),
		.out_avg  (div_avg)
	);

	always_comb begin
		fin_data = {div_avg, div_item.vel, div_item.alt};
	end

	// Output register with a skid stage behind it.
	assign main_free = !main_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= div_valid;
			end
		end else if (en && div_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_data_q <= skid_valid_q ? skid_data_q : fin_data;
		end else if (en && div_valid) begin
			skid_data_q <= fin_data;
		end
	end

	assign m_tvalid = main_valid_q;
	assign m_tdata  = main_data_q;

endmodule

>>> src/bvve_velocity.sv
// Front end of the estimator: altitude difference, gain and the smoothed velocity loop.
// Three stages; the velocity register closes the recurrence.
// Depends on bvve_pkg.
module bvve_velocity (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic signed [bvve_pkg::DATA_W-1:0] altitude,
	output logic                          out_valid,
	output bvve_pkg::item_t               out_item
);
	import bvve_pkg::*;

	logic signed [DATA_W-1:0] prev_q;
	logic signed [DATA_W-1:0] vel_q;

	logic                     valid_s1, valid_s2, valid_s3;
	logic signed [DIFF_W-1:0] diff_s1;
	logic                     upd_s1, upd_s2;
	logic signed [DATA_W-1:0] alt_s1, alt_s2, alt_s3;
	logic signed [GAIN_W-1:0] d40_s2;

	logic signed [GAIN_W-1:0]  dx;
	logic signed [PROD_W-1:0]  prod;
	logic signed [DECAY_W-1:0] decay;
	logic signed [VSUM_W-1:0]  vsum;
	logic signed [DATA_W-1:0]  vel_next;

	// Difference widened for the gain of 40, which is built as two shifted copies of it.
	always_comb begin
		dx = GAIN_W'(diff_s1);
	end

	// Decay, add and saturate for the velocity recurrence.
	always_comb begin
		prod  = PROD_W'(vel_q) * PROD_W'(DECAY_MUL);
		decay = prod[PROD_W-1:DECAY_SHIFT];
		vsum  = VSUM_W'(decay) + VSUM_W'(d40_s2);
		if (vsum > VSUM_W'(VEL_MAX)) begin
			vel_next = VEL_MAX;
		end else if (vsum < VSUM_W'(VEL_MIN)) begin
			vel_next = VEL_MIN;
		end else begin
			vel_next = vsum[DATA_W-1:0];
		end
	end

	// Control state and the two stored values of the recurrence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			prev_q   <= '0;
			vel_q    <= '0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			if (in_valid) begin
				prev_q <= altitude;
			end
			if (valid_s2 && upd_s2) begin
				vel_q <= vel_next;
			end
		end
	end

	// Payload stages.
	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= DIFF_W'(altitude) - DIFF_W'(prev_q);
			upd_s1  <= (prev_q != '0);
			alt_s1  <= altitude;
			d40_s2  <= (dx <<< GAIN_SH_HI) + (dx <<< GAIN_SH_LO);
			upd_s2  <= upd_s1;
			alt_s2  <= alt_s1;
			alt_s3  <= alt_s2;
		end
	end

	assign out_valid    = valid_s3;
	assign out_item.alt = alt_s3;
	assign out_item.vel = vel_q;

endmodule

>>> src/bvve_win_cell.sv
// One cell of the velocity window: holds a single velocity and hands it on.
// The cells form a shift line whose last cell holds the oldest velocity.
// Depends on bvve_pkg.
module bvve_win_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               shift,
	input  logic signed [bvve_pkg::DATA_W-1:0] d,
	output logic signed [bvve_pkg::DATA_W-1:0] q
);
	import bvve_pkg::*;

	logic signed [DATA_W-1:0] val_q;

	// The window starts cleared, so an unfilled entry counts as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (shift) begin
			val_q <= d;
		end
	end

	assign q = val_q;

endmodule

>>> src/bvve_div_cell.sv
// Divider of the signed window sum by WINDOW_LEN, truncating towards zero.
// Multiplies the magnitude by a fixed reciprocal as split partial products over three stages.
// Depends on bvve_pkg.
module bvve_div_cell #(
	parameter int unsigned SUM_W   = 36,
	parameter int unsigned DIVISOR = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  bvve_pkg::item_t             in_item,
	input  logic [SUM_W-1:0]            in_sum,
	output logic                        out_valid,
	output bvve_pkg::item_t             out_item,
	output logic [bvve_pkg::DATA_W-1:0] out_avg
);
	import bvve_pkg::*;

	// With a shift of the magnitude width plus clog2 of the divisor, the rounded-up
	// reciprocal gives the exact floored quotient for every magnitude that can occur.
	localparam int unsigned RCP_SH = SUM_W + $clog2(DIVISOR);
	localparam int unsigned RCP_W  = SUM_W + 1;
	localparam logic [63:0] RCP64  = ((64'd1 << RCP_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [RCP_W-1:0] RCP = RCP64[RCP_W-1:0];

	// Both operands are split at LO_W bits so that each partial product stays small.
	localparam int unsigned LO_W = 20;
	localparam int unsigned NH_W = SUM_W - LO_W;
	localparam int unsigned MH_W = RCP_W - LO_W;
	localparam int unsigned LL_W = LO_W + LO_W;
	localparam int unsigned LH_W = LO_W + MH_W;
	localparam int unsigned HL_W = NH_W + LO_W;
	localparam int unsigned HH_W = NH_W + MH_W;
	localparam int unsigned PP_W = SUM_W + RCP_W;

	logic              valid_s5, valid_s6, valid_s7;
	item_t             item_s5, item_s6, item_s7;
	logic              neg_s5, neg_s6, neg_s7;
	logic [SUM_W-1:0]  mag_s5;
	logic [LL_W-1:0]   pp_ll_s6;
	logic [LH_W-1:0]   pp_lh_s6;
	logic [HL_W-1:0]   pp_hl_s6;
	logic [HH_W-1:0]   pp_hh_s6;
	logic [DATA_W-1:0] quo_s7;

	logic [LO_W-1:0]   n_lo;
	logic [NH_W-1:0]   n_hi;
	logic [PP_W-1:0]   prod;

	// Halves of the magnitude for the partial products.
	always_comb begin
		n_lo = mag_s5[LO_W-1:0];
		n_hi = mag_s5[SUM_W-1:LO_W];
	end

	// Full product of magnitude and reciprocal, rebuilt from the four partial products.
	always_comb begin
		prod = (PP_W'(pp_hh_s6) << LL_W)
			+ (PP_W'(pp_lh_s6) << LO_W)
			+ (PP_W'(pp_hl_s6) << LO_W)
			+ PP_W'(pp_ll_s6);
	end

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s5 <= in_valid;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// Magnitude, partial products, then the quotient taken from the top of the product.
	always_ff @(posedge clk) begin
		if (en) begin
			item_s5  <= in_item;
			neg_s5   <= in_sum[SUM_W-1];
			mag_s5   <= in_sum[SUM_W-1] ? (~in_sum + SUM_W'(1)) : in_sum;
			item_s6  <= item_s5;
			neg_s6   <= neg_s5;
			pp_ll_s6 <= LL_W'(n_lo) * LL_W'(RCP[LO_W-1:0]);
			pp_lh_s6 <= LH_W'(n_lo) * LH_W'(RCP[RCP_W-1:LO_W]);
			pp_hl_s6 <= HL_W'(n_hi) * HL_W'(RCP[LO_W-1:0]);
			pp_hh_s6 <= HH_W'(n_hi) * HH_W'(RCP[RCP_W-1:LO_W]);
			item_s7  <= item_s6;
			neg_s7   <= neg_s6;
			quo_s7   <= prod[RCP_SH +: DATA_W];
		end
	end

	// The sign of the sum is put back on the truncated quotient.
	assign out_valid = valid_s7;
	assign out_item  = item_s7;
	assign out_avg   = neg_s7 ? (~quo_s7 + DATA_W'(1)) : quo_s7;

endmodule

>>> src/bvve_checker.sv
// Port-level checks for the barometric vertical velocity estimator.
// Watches only the top-level ports and is attached by the bind statement at the end.
// Depends on baro_vertical_velocity_estimator.
module bvve_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata
);

	logic [7:0]  inflight_q;
	logic        first_q;
	logic        taken_q;
	logic [31:0] first_alt_q;

	// Beats taken in but not yet delivered, and whether the first result is still due.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
			first_q    <= 1'b1;
		end else begin
			inflight_q <= inflight_q + 8'(s_tvalid && s_tready) - 8'(m_tvalid && m_tready);
			if (m_tvalid && m_tready) begin
				first_q <= 1'b0;
			end
		end
	end

	// The altitude of the first sample taken after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q     <= 1'b0;
			first_alt_q <= '0;
		end else if (s_tvalid && s_tready && !taken_q) begin
			taken_q     <= 1'b1;
			first_alt_q <= s_tdata;
		end
	end

	// A stalled result beat holds its data.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// No result beat without a sample behind it.
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> inflight_q != 8'd0)
		else $error("result beat shown with no sample in flight");

	// The input side only closes after the output side has stalled.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> $past(m_tvalid && !m_tready))
		else $error("input closed without an output stall");

	// The first result after reset echoes the first sample with zero velocity and average.
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && first_q |-> m_tdata[95:32] == 64'd0 && m_tdata[31:0] == first_alt_q)
		else $error("first result does not match the first sample");

endmodule

bind baro_vertical_velocity_estimator bvve_checker u_bvve_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
